// ===== hdl/dxfc_pkg.sv =====
// Package with constants and helper functions for the double/extended converter.
package dxfc_pkg;

    // Conversion direction carried in tuser.
    localparam logic ModeWiden  = 1'b0;
    localparam logic ModeNarrow = 1'b1;

    // Extended exponent bias and field masks.
    localparam logic [14:0] ExtBias     = 15'd16383;
    localparam logic [15:0] SignBit16   = 16'h8000;
    localparam logic [15:0] ExpMask15   = 16'h7FFF;
    localparam logic [63:0] DblQnan     = 64'h7FF8000000000000;
    localparam logic [63:0] DblInf      = 64'h7FF0000000000000;
    // Extended bias minus double bias, and extended bias plus the smallest denormal exponent.
    localparam logic [14:0] NormOffset  = 15'd15360;
    localparam logic [14:0] DenOffset   = 15'd15309;

    // Stream widths: 80 bits of data packed into whole bytes.
    localparam int TdataWidth = 80;
    localparam int TuserWidth = 1;

    // Position of the most significant set bit; zero for an all-zero word.
    function automatic logic [5:0] lead_pos64(input logic [63:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    // Right shift with round to nearest, ties to even; shifts of 64 or more give zero.
    function automatic logic [63:0] rne_rshift(input logic [63:0] v, input logic [7:0] sh);
        logic [63:0] q;
        logic [63:0] low_mask;
        logic [63:0] rem;
        logic [63:0] half;
        logic        up;
        if (sh >= 8'd64) begin
            return 64'd0;
        end
        q        = v >> sh[5:0];
        low_mask = (64'd1 << sh[5:0]) - 64'd1;
        rem      = v & low_mask;
        half     = (sh == 8'd0) ? 64'd0 : (64'd1 << (sh[5:0] - 6'd1));
        up       = (sh != 8'd0) && ((rem > half) || ((rem == half) && q[0]));
        return q + {63'd0, up};
    endfunction

endpackage

// ===== hdl/double_extended_float_convert_core.sv =====
// Top level of the converter between IEEE double and 80-bit extended format.
//
//  Channel  Dir  tdata (low bit up)                                tuser
//  s_       in   ext_sign_exponent[15:0], payload[79:16]           mode
//  m_       out  out_sign_exponent[15:0], out_payload[79:16]       unsupported
//
// One transaction per cycle is sustained while m_tready stays high; an accepted transaction
// passes from the input register into the result register, where its result becomes valid.
// Normalization and rounding are done in one combinational pass between them.
// Reset (aresetn low, synchronous) empties both registers.
// A stall on m_tready holds the result; s_tready drops in the same cycle once the
// input register is also full.
module double_extended_float_convert_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // ext_sign_exponent [15:0], payload [79:16]
    input  logic [dxfc_pkg::TdataWidth-1:0]      s_tdata,
    // mode [0]
    input  logic [dxfc_pkg::TuserWidth-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_sign_exponent [15:0], out_payload [79:16]
    output logic [dxfc_pkg::TdataWidth-1:0]      m_tdata,
    // unsupported [0]
    output logic [dxfc_pkg::TuserWidth-1:0]      m_tuser
);

    logic        in_vld_reg;
    logic        mode_reg;
    logic [15:0] se_reg;
    logic [63:0] pay_reg;
    logic        out_vld_reg;
    logic [15:0] out_se_reg;
    logic [63:0] out_pay_reg;
    logic        unsup_reg;

    logic        out_adv;
    logic [15:0] se_next;
    logic [63:0] pay_next;
    logic        unsup_next;

    // Handshake: each stage advances when the stage after it is free.
    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            mode_reg <= s_tuser[0];
            se_reg   <= s_tdata[15:0];
            pay_reg  <= s_tdata[79:16];
        end
    end

    // Widening fields.
    logic        w_sgn;
    logic [10:0] w_bexp;
    logic [51:0] w_frac;
    logic [5:0]  w_p;
    // Narrowing fields.
    logic        n_sgn;
    logic [14:0] n_exp;
    logic signed [17:0] n_e;
    logic [5:0]  n_l;
    logic [63:0] n_r;
    logic [52:0] n_sig;
    logic signed [17:0] n_x;
    logic signed [17:0] n_b;
    logic signed [17:0] n_sh;
    logic [63:0] n_res;

    // Conversion in one pass.
    always_comb begin
        se_next    = 16'd0;
        pay_next   = 64'd0;
        unsup_next = 1'b0;

        w_sgn  = pay_reg[63];
        w_bexp = pay_reg[62:52];
        w_frac = pay_reg[51:0];
        w_p    = dxfc_pkg::lead_pos64({12'd0, w_frac});

        n_sgn = se_reg[15];
        n_exp = se_reg[14:0];
        n_e   = $signed({3'd0, n_exp}) - $signed({3'd0, dxfc_pkg::ExtBias});
        n_l   = dxfc_pkg::lead_pos64(pay_reg);
        n_r   = 64'd0;
        n_sig = 53'd0;
        n_x   = 18'sd0;
        n_b   = 18'sd0;
        n_sh  = 18'sd0;
        n_res = 64'd0;

        if (mode_reg == dxfc_pkg::ModeWiden) begin
            // Widen double to extended.
            if (w_bexp == 11'h7FF) begin
                unsup_next = 1'b1;
            end else if (w_bexp != 11'd0) begin
                se_next  = {w_sgn, 15'({4'd0, w_bexp}) + dxfc_pkg::NormOffset};
                pay_next = {1'b1, w_frac, 11'd0};
            end else if (w_frac != 52'd0) begin
                se_next  = {w_sgn, 15'({9'd0, w_p}) + dxfc_pkg::DenOffset};
                pay_next = {12'd0, w_frac} << (6'd63 - w_p);
            end
        end else begin
            // Narrow extended to double: round to 53 bits, then scale.
            if (n_e > 18'sd1023) begin
                n_res = (pay_reg == 64'd0) ? dxfc_pkg::DblQnan : dxfc_pkg::DblInf;
            end else if (n_e < -18'sd1074 || pay_reg == 64'd0) begin
                n_res = 64'd0;
            end else begin
                n_x = n_e + $signed({12'd0, n_l}) - 18'sd63;
                if (n_l <= 6'd52) begin
                    n_r   = pay_reg << (6'd52 - n_l);
                    n_sig = n_r[52:0];
                end else begin
                    n_r = dxfc_pkg::rne_rshift(pay_reg, {2'd0, n_l - 6'd52});
                    if (n_r[53]) begin
                        n_sig = n_r[53:1];
                        n_x   = n_x + 18'sd1;
                    end else begin
                        n_sig = n_r[52:0];
                    end
                end
                n_b = n_x + 18'sd1023;
                if (n_b >= 18'sd2047) begin
                    n_res = dxfc_pkg::DblInf;
                end else if (n_b >= 18'sd1) begin
                    n_res = {1'b0, n_b[10:0], n_sig[51:0]};
                end else begin
                    n_sh = 18'sd1 - n_b;
                    if (n_sh >= 18'sd64) begin
                        n_res = 64'd0;
                    end else begin
                        n_res = dxfc_pkg::rne_rshift({11'd0, n_sig}, n_sh[7:0]);
                    end
                end
            end
            pay_next = n_res | {n_sgn, 63'd0};
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= in_vld_reg;
        end
        if (out_adv && in_vld_reg) begin
            out_se_reg  <= se_next;
            out_pay_reg <= pay_next;
            unsup_reg   <= unsup_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_pay_reg, out_se_reg};
    assign m_tuser  = unsup_reg;

    // A held input item moves into a free result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("input item did not advance into free result register");

    // An unsupported result carries zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("unsupported result has nonzero data");

    // Narrowing never yields a sign/exponent word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && mode_reg == dxfc_pkg::ModeNarrow) |-> (se_next == 16'd0 && !unsup_next))
        else $error("narrowing produced sign/exponent or flag");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
